// File: rtl/lwws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwws_pkg
// Shared types and constants of the LCD window write sequencer.
// ----------------------------------------------------------------------------
package lwws_pkg;

    localparam int CoordW = 10;
    localparam int DimW   = 11;
    localparam int WordW  = 16;
    localparam int CountW = 21;
    localparam int ByteW  = 8;
    localparam int CfgIdxW = 2;
    localparam int StepW  = 4;

    localparam logic [CountW-1:0] COUNT_MAX = 21'h1fffff;
    localparam logic [WordW-1:0]  WORD_MINUS_ONE = 16'hffff;

    localparam logic REQ_AREA  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_COLUMN_SET   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROW_SET      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MEMORY_WRITE = 2'd2;

    localparam logic [ByteW-1:0] COLUMN_SET_RESET   = 8'd42;
    localparam logic [ByteW-1:0] ROW_SET_RESET      = 8'd43;
    localparam logic [ByteW-1:0] MEMORY_WRITE_RESET = 8'd44;

    // byte positions within an area header
    localparam logic [StepW-1:0] BYTE_COL_CMD = 4'd0;
    localparam logic [StepW-1:0] BYTE_X_HI    = 4'd1;
    localparam logic [StepW-1:0] BYTE_X_LO    = 4'd2;
    localparam logic [StepW-1:0] BYTE_XE_HI   = 4'd3;
    localparam logic [StepW-1:0] BYTE_XE_LO   = 4'd4;
    localparam logic [StepW-1:0] BYTE_ROW_CMD = 4'd5;
    localparam logic [StepW-1:0] BYTE_Y_HI    = 4'd6;
    localparam logic [StepW-1:0] BYTE_Y_LO    = 4'd7;
    localparam logic [StepW-1:0] BYTE_YE_HI   = 4'd8;
    localparam logic [StepW-1:0] BYTE_YE_LO   = 4'd9;
    localparam logic [StepW-1:0] BYTE_MEM_CMD = 4'd10;

    // byte positions within a pixel
    localparam logic [StepW-1:0] BYTE_PIX_HI  = 4'd0;
    localparam logic [StepW-1:0] BYTE_PIX_LO  = 4'd1;

    localparam int JOB_FIFO_DEPTH = 2;

    typedef struct packed {
        logic              is_area;
        logic [CoordW-1:0] x;
        logic [WordW-1:0]  x_end;
        logic [CoordW-1:0] y;
        logic [WordW-1:0]  y_end;
        logic [WordW-1:0]  pixel;
        logic              done;
    } job_t;

    typedef struct packed {
        logic [ByteW-1:0] column_set;
        logic [ByteW-1:0] row_set;
        logic [ByteW-1:0] memory_write;
    } codes_t;

endpackage

// File: rtl/lwws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwws_if
// Request, link byte and configuration channels of the sequencer.
// ----------------------------------------------------------------------------
interface lwws_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [lwws_pkg::CoordW-1:0] area_x;
    logic [lwws_pkg::CoordW-1:0] area_y;
    logic [lwws_pkg::DimW-1:0]   area_w;
    logic [lwws_pkg::DimW-1:0]   area_h;
    logic [lwws_pkg::WordW-1:0]  pixel;

    modport source (output valid, req_type, area_x, area_y, area_w, area_h, pixel,
                    input ready);
    modport sink   (input valid, req_type, area_x, area_y, area_w, area_h, pixel,
                    output ready);
endinterface

interface lwws_link_if;
    logic                       valid;
    logic                       ready;
    logic [lwws_pkg::ByteW-1:0] out_byte;
    logic                       is_command;
    logic                       last;
    logic                       area_done;

    modport source (output valid, out_byte, is_command, last, area_done, input ready);
    modport sink   (input valid, out_byte, is_command, last, area_done, output ready);
endinterface

interface lwws_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lwws_pkg::CfgIdxW-1:0] index;
    logic [lwws_pkg::ByteW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lwws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwws_front
// Accepts requests, tracks the open area and queues byte jobs.
// ----------------------------------------------------------------------------
module lwws_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    lwws_req_if.sink           req,
    output logic               push_valid,
    output lwws_pkg::job_t     push_job,
    input  logic               push_ready
);

    localparam int DimW   = lwws_pkg::DimW;
    localparam int CountW = lwws_pkg::CountW;
    localparam int WordW  = lwws_pkg::WordW;
    localparam int CoordW = lwws_pkg::CoordW;
    localparam logic [16:0]     MaxDimCmp = 17'(MAX_DIM);
    localparam logic [DimW-1:0] DimClip   = (MAX_DIM > 2047) ? {DimW{1'b1}} : DimW'(MAX_DIM);

    logic [CountW-1:0]   pixels_left_reg;
    logic [CountW-1:0]   pixels_left_next;
    logic [DimW-1:0]     w_clamped;
    logic [DimW-1:0]     h_clamped;
    logic [2*DimW-1:0]   product;
    logic [CountW-1:0]   count;
    logic                accept;
    logic                area_open;

    assign req.ready = push_ready;
    assign accept    = req.valid && push_ready;
    assign area_open = (pixels_left_reg != '0);

    assign w_clamped = ({6'd0, req.area_w} > MaxDimCmp) ? DimClip : req.area_w;
    assign h_clamped = ({6'd0, req.area_h} > MaxDimCmp) ? DimClip : req.area_h;
    assign product   = w_clamped * h_clamped;
    assign count     = product[2*DimW-1] ? lwws_pkg::COUNT_MAX : product[CountW-1:0];

    always_comb
    begin
        push_job.is_area = (req.req_type == lwws_pkg::REQ_AREA);
        push_job.x       = req.area_x;
        push_job.y       = req.area_y;
        push_job.x_end   = {{(WordW-CoordW){1'b0}}, req.area_x}
                           + {{(WordW-DimW){1'b0}}, w_clamped} + lwws_pkg::WORD_MINUS_ONE;
        push_job.y_end   = {{(WordW-CoordW){1'b0}}, req.area_y}
                           + {{(WordW-DimW){1'b0}}, h_clamped} + lwws_pkg::WORD_MINUS_ONE;
        push_job.pixel   = req.pixel;
        push_job.done    = (pixels_left_reg == CountW'(1));
    end

    assign push_valid = accept && ((req.req_type == lwws_pkg::REQ_AREA) || area_open);

    always_comb
    begin
        pixels_left_next = pixels_left_reg;
        if (accept)
        begin
            if (req.req_type == lwws_pkg::REQ_AREA)
                pixels_left_next = count;
            else if (area_open)
                pixels_left_next = pixels_left_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixels_left_reg <= '0;
        else
            pixels_left_reg <= pixels_left_next;
    end

endmodule

// File: rtl/lwws_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwws_job_fifo
// Short job queue between the request front and the byte back end.
// ----------------------------------------------------------------------------
module lwws_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  lwws_pkg::job_t push_job,
    output logic           push_ready,
    output logic           head_valid,
    output lwws_pkg::job_t head_job,
    input  logic           pop
);

    localparam int Depth  = lwws_pkg::JOB_FIFO_DEPTH;
    localparam int PtrW   = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);

    lwws_pkg::job_t    entries_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CountW-1:0] fill_reg;
    logic [CountW-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != CountW'(Depth));
    assign head_valid = (fill_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CountW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CountW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/lwws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwws_back
// Walks each queued job byte by byte into the link output register.
// ----------------------------------------------------------------------------
module lwws_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  lwws_pkg::job_t   head_job,
    output logic             pop,
    input  lwws_pkg::codes_t codes,
    lwws_link_if.source      link
);

    localparam int StepW = lwws_pkg::StepW;
    localparam int ByteW = lwws_pkg::ByteW;
    localparam int WordW = lwws_pkg::WordW;
    localparam int CoordW = lwws_pkg::CoordW;

    logic [StepW-1:0] step_reg;
    logic [StepW-1:0] step_next;
    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] byte_reg;
    logic             cmd_reg;
    logic             last_reg;
    logic             done_reg;
    logic [ByteW-1:0] sel_byte;
    logic             sel_cmd;
    logic             sel_last;
    logic             sel_done;
    logic             load;
    logic [WordW-1:0] x_word;
    logic [WordW-1:0] y_word;

    assign x_word = {{(WordW-CoordW){1'b0}}, head_job.x};
    assign y_word = {{(WordW-CoordW){1'b0}}, head_job.y};

    always_comb
    begin
        sel_byte = '0;
        sel_cmd  = 1'b0;
        sel_last = 1'b0;
        sel_done = 1'b0;
        if (head_job.is_area)
        begin
            case (step_reg)
                lwws_pkg::BYTE_COL_CMD:
                begin
                    sel_byte = codes.column_set;
                    sel_cmd  = 1'b1;
                end
                lwws_pkg::BYTE_X_HI:  sel_byte = x_word[15:8];
                lwws_pkg::BYTE_X_LO:  sel_byte = x_word[7:0];
                lwws_pkg::BYTE_XE_HI: sel_byte = head_job.x_end[15:8];
                lwws_pkg::BYTE_XE_LO: sel_byte = head_job.x_end[7:0];
                lwws_pkg::BYTE_ROW_CMD:
                begin
                    sel_byte = codes.row_set;
                    sel_cmd  = 1'b1;
                end
                lwws_pkg::BYTE_Y_HI:  sel_byte = y_word[15:8];
                lwws_pkg::BYTE_Y_LO:  sel_byte = y_word[7:0];
                lwws_pkg::BYTE_YE_HI: sel_byte = head_job.y_end[15:8];
                lwws_pkg::BYTE_YE_LO: sel_byte = head_job.y_end[7:0];
                default:
                begin
                    sel_byte = codes.memory_write;
                    sel_cmd  = 1'b1;
                    sel_last = 1'b1;
                end
            endcase
        end
        else
        begin
            if (step_reg == lwws_pkg::BYTE_PIX_HI)
                sel_byte = head_job.pixel[15:8];
            else
            begin
                sel_byte = head_job.pixel[7:0];
                sel_last = 1'b1;
                sel_done = head_job.done;
            end
        end
    end

    assign load = head_valid && (!valid_reg || link.ready);
    assign pop  = load && sel_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = sel_last ? '0 : step_reg + StepW'(1);
            valid_next = 1'b1;
        end
        else if (link.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            cmd_reg  <= sel_cmd;
            last_reg <= sel_last;
            done_reg <= sel_done;
        end
    end

    assign link.valid      = valid_reg;
    assign link.out_byte   = byte_reg;
    assign link.is_command = cmd_reg;
    assign link.last       = last_reg;
    assign link.area_done  = done_reg;

endmodule

// File: rtl/lcd_window_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_window_write_sequencer
// Byte sequencer for a serial display controller: window setup and pixels.
//
// req  : area requests (req_type 0) and pixels (req_type 1), valid/ready.
// link : one byte per transaction with command/data flag, last, area_done.
// cfg  : writes of the column-set, row-set and memory-write command codes.
// An area request yields 11 link bytes, one per cycle while link is ready;
// a pixel yields two, as the output register holds one byte per cycle.
// The first byte is registered in the job queue and then in the output
// register before it is valid on the link.
// Pixels arriving with no area open are consumed and produce nothing.
// A 2-entry job queue decouples the front from the byte back end, so
// requests keep flowing while the link holds a byte during a stall; when
// the queue fills, req.ready drops until the back end catches up.
// Reset clears the pixel count (no area open), empties the queue and
// restores the command codes to 42, 43 and 44. cfg is always ready.
// ----------------------------------------------------------------------------
module lcd_window_write_sequencer #(
    parameter int MAX_DIM = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    lwws_req_if.sink    req,
    lwws_link_if.source link,
    lwws_cfg_if.sink    cfg
);

    lwws_pkg::codes_t codes_reg;
    lwws_pkg::codes_t codes_next;
    logic             push_valid;
    lwws_pkg::job_t   push_job;
    logic             push_ready;
    logic             head_valid;
    lwws_pkg::job_t   head_job;
    logic             pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        codes_next = codes_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                lwws_pkg::CFG_COLUMN_SET:   codes_next.column_set   = cfg.data;
                lwws_pkg::CFG_ROW_SET:      codes_next.row_set      = cfg.data;
                lwws_pkg::CFG_MEMORY_WRITE: codes_next.memory_write = cfg.data;
                default:                    codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.column_set   <= lwws_pkg::COLUMN_SET_RESET;
            codes_reg.row_set      <= lwws_pkg::ROW_SET_RESET;
            codes_reg.memory_write <= lwws_pkg::MEMORY_WRITE_RESET;
        end
        else
            codes_reg <= codes_next;
    end

    lwws_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    lwws_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    lwws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .codes      (codes_reg),
        .link       (link)
    );

endmodule

// File: dv/tb_lcd_window_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_window_write_sequencer
// Self-checking bench for the window write byte sequencer.
//
// A directed table covers empty and oversized areas, window end wrap, area
// replacement, dropped pixels and the last pixel of an area. Random phases
// follow, each under a new set of command codes. Every accepted request is
// run through a local predictor, and each link byte is checked against the
// oldest predicted byte. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_lcd_window_write_sequencer;

    localparam int CoordW  = lwws_pkg::CoordW;
    localparam int DimW    = lwws_pkg::DimW;
    localparam int WordW   = lwws_pkg::WordW;
    localparam int CountW  = lwws_pkg::CountW;
    localparam int ByteW   = lwws_pkg::ByteW;
    localparam int CfgIdxW = lwws_pkg::CfgIdxW;

    localparam int MAX_DIM      = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [DimW-1:0]   w;
        logic [DimW-1:0]   h;
        logic [WordW-1:0]  pix;
    } req_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             cmd;
        logic             fin;
        logic             done;
    } link_byte_t;

    typedef struct {
        req_t             item;
        bit               typed;
        logic [WordW-1:0] x_end;
        logic [WordW-1:0] y_end;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lwws_req_if  req_ch ();
    lwws_link_if link_ch ();
    lwws_cfg_if  cfg_ch ();

    lcd_window_write_sequencer #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .link (link_ch),
        .cfg  (cfg_ch)
    );

    // predictor state
    logic [ByteW-1:0]  col_code    = lwws_pkg::COLUMN_SET_RESET;
    logic [ByteW-1:0]  row_code    = lwws_pkg::ROW_SET_RESET;
    logic [ByteW-1:0]  mem_code    = lwws_pkg::MEMORY_WRITE_RESET;
    logic [CountW-1:0] pixels_open = '0;

    link_byte_t pending_link_bytes[$];
    int         useful_items   = 0;
    int         byte_mismatches = 0;
    int         cycles         = 0;
    bit         req_burst      = 0;
    bit         link_burst     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [DimW-1:0] clip_dim(input logic [DimW-1:0] d);
        return (d > MAX_DIM) ? DimW'(MAX_DIM) : d;
    endfunction

    function automatic void expect_byte(input logic [ByteW-1:0] b, input logic cmd,
                                        input logic fin, input logic done);
        pending_link_bytes.push_back('{b, cmd, fin, done});
    endfunction

    function automatic void expect_range(input logic [WordW-1:0] first,
                                         input logic [WordW-1:0] last_pos);
        expect_byte(first[15:8], 1'b0, 1'b0, 1'b0);
        expect_byte(first[7:0], 1'b0, 1'b0, 1'b0);
        expect_byte(last_pos[15:8], 1'b0, 1'b0, 1'b0);
        expect_byte(last_pos[7:0], 1'b0, 1'b0, 1'b0);
    endfunction

    // Typed window ends, when given, stand in for the computed ones.
    function automatic void predict_link_bytes(input req_t it, input bit typed,
                                               input logic [WordW-1:0] txe,
                                               input logic [WordW-1:0] tye);
        logic [DimW-1:0]   w;
        logic [DimW-1:0]   h;
        logic [WordW-1:0]  xe;
        logic [WordW-1:0]  ye;
        logic [2*DimW-1:0] area_px;
        if (it.kind == lwws_pkg::REQ_AREA)
        begin
            w       = clip_dim(it.w);
            h       = clip_dim(it.h);
            xe      = WordW'(it.x) + WordW'(w) + lwws_pkg::WORD_MINUS_ONE;
            ye      = WordW'(it.y) + WordW'(h) + lwws_pkg::WORD_MINUS_ONE;
            area_px = w * h;
            if (typed)
            begin
                xe = txe;
                ye = tye;
            end
            expect_byte(col_code, 1'b1, 1'b0, 1'b0);
            expect_range(WordW'(it.x), xe);
            expect_byte(row_code, 1'b1, 1'b0, 1'b0);
            expect_range(WordW'(it.y), ye);
            expect_byte(mem_code, 1'b1, 1'b1, 1'b0);
            pixels_open = (area_px > lwws_pkg::COUNT_MAX) ? lwws_pkg::COUNT_MAX
                                                           : area_px[CountW-1:0];
            useful_items++;
        end
        else if (pixels_open != '0)
        begin
            expect_byte(it.pix[15:8], 1'b0, 1'b0, 1'b0);
            expect_byte(it.pix[7:0], 1'b0, 1'b1, pixels_open == 1);
            pixels_open = pixels_open - 1'b1;
            useful_items++;
        end
    endfunction

    function automatic req_t mk_area(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                     input logic [DimW-1:0] w, input logic [DimW-1:0] h);
        return '{lwws_pkg::REQ_AREA, x, y, w, h, WordW'($urandom)};
    endfunction

    function automatic req_t mk_pixel(input logic [WordW-1:0] p);
        return '{lwws_pkg::REQ_PIXEL, CoordW'($urandom), CoordW'($urandom), DimW'($urandom),
                 DimW'($urandom), p};
    endfunction

    task automatic send_req(input req_t it, input bit typed = 1'b0,
                            input logic [WordW-1:0] txe = '0,
                            input logic [WordW-1:0] tye = '0);
        int gap;
        if ($urandom_range(0, 15) == 0)
            req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= it.kind;
        req_ch.area_x   <= it.x;
        req_ch.area_y   <= it.y;
        req_ch.area_w   <= it.w;
        req_ch.area_h   <= it.h;
        req_ch.pixel    <= it.pix;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_link_bytes(it, typed, txe, tye);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            lwws_pkg::CFG_COLUMN_SET:   col_code = val;
            lwws_pkg::CFG_ROW_SET:      row_code = val;
            lwws_pkg::CFG_MEMORY_WRITE: mem_code = val;
            default: ;
        endcase
    endtask

    task automatic program_codes(input logic [ByteW-1:0] col, input logic [ByteW-1:0] row,
                                 input logic [ByteW-1:0] mem);
        write_reg(lwws_pkg::CFG_COLUMN_SET, col);
        write_reg(lwws_pkg::CFG_ROW_SET, row);
        write_reg(lwws_pkg::CFG_MEMORY_WRITE, mem);
        write_reg(CFG_UNUSED, ByteW'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Dropped pixels leave no byte behind, so allow the pipe to drain as well.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_link_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_useful);
        int goal;
        int sel;
        int w;
        int h;
        int n;
        goal = useful_items + n_useful;
        while (useful_items < goal)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 3);
                send_req(mk_area(CoordW'($urandom), CoordW'($urandom), DimW'(w), DimW'(h)));
                repeat (w * h) send_req(mk_pixel(WordW'($urandom)));
            end
            else if (sel == 7)
            begin
                // oversized or odd window cut short; the next area replaces it
                send_req(mk_area(CoordW'($urandom), CoordW'($urandom),
                                 DimW'($urandom), DimW'($urandom)));
                n = $urandom_range(0, 3);
                repeat (n) send_req(mk_pixel(WordW'($urandom)));
            end
            else if (sel == 8)
            begin
                w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2047);
                h = (w == 0) ? $urandom_range(0, 2047) : 0;
                send_req(mk_area(CoordW'($urandom), CoordW'($urandom), DimW'(w), DimW'(h)));
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_req(mk_pixel(WordW'($urandom)));
            end
        end
    endtask

    // link side: random backpressure and checking
    initial
    begin
        int         stall;
        link_byte_t got;
        link_byte_t want;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                link_burst = !link_burst;
            stall = link_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                link_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            link_ch.ready <= 1'b1;
            @(posedge clk);
            while (link_ch.valid !== 1'b1)
                @(posedge clk);
            got = '{link_ch.out_byte, link_ch.is_command, link_ch.last, link_ch.area_done};
            if (pending_link_bytes.size() == 0)
            begin
                byte_mismatches++;
                if (byte_mismatches <= 10)
                    $display("unexpected link byte %h cmd %b last %b done %b",
                             got.data, got.cmd, got.fin, got.done);
            end
            else
            begin
                want = pending_link_bytes.pop_front();
                if (got.data !== want.data || got.cmd !== want.cmd ||
                    got.fin !== want.fin || got.done !== want.done)
                begin
                    byte_mismatches++;
                    if (byte_mismatches <= 10)
                        $display({"link byte: expected %h cmd %b last %b done %b, ",
                                  "got %h cmd %b last %b done %b"},
                                 want.data, want.cmd, want.fin, want.done,
                                 got.data, got.cmd, got.fin, got.done);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t rows[$];
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= lwws_pkg::REQ_AREA;
        req_ch.area_x   <= '0;
        req_ch.area_y   <= '0;
        req_ch.area_w   <= '0;
        req_ch.area_h   <= '0;
        req_ch.pixel    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= lwws_pkg::CFG_COLUMN_SET;
        cfg_ch.data     <= '0;

        rows.push_back('{mk_area(0, 0, 0, 0), 1'b1, 16'hffff, 16'hffff});
        rows.push_back('{mk_pixel(16'h1234), 1'b0, '0, '0});
        rows.push_back('{mk_area(1023, 1023, 2047, 2047), 1'b1, 16'h07fe, 16'h07fe});
        rows.push_back('{mk_pixel(16'hffff), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h0000), 1'b0, '0, '0});
        rows.push_back('{mk_area(5, 7, 1, 1), 1'b1, 16'h0005, 16'h0007});
        rows.push_back('{mk_pixel(16'ha55a), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h5aa5), 1'b0, '0, '0});
        rows.push_back('{mk_area(0, 1023, 1024, 1), 1'b1, 16'h03ff, 16'h03ff});
        rows.push_back('{mk_pixel(16'h8000), 1'b0, '0, '0});
        rows.push_back('{mk_area(10, 20, 2, 3), 1'b1, 16'h000b, 16'h0016});
        rows.push_back('{mk_pixel(16'h00ff), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h7fff), 1'b0, '0, '0});
        rows.push_back('{mk_area(512, 256, 3, 2), 1'b1, 16'h0202, 16'h0101});
        rows.push_back('{mk_pixel(16'h0f0f), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'hf0f0), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h1111), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h2222), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h4444), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h8888), 1'b0, '0, '0});
        rows.push_back('{mk_pixel(16'h3c3c), 1'b0, '0, '0});
        rows.push_back('{mk_area(100, 200, 3, 0), 1'b1, 16'h0066, 16'h00c7});
        rows.push_back('{mk_pixel(16'hdead), 1'b0, '0, '0});
        rows.push_back('{mk_area(1, 1, 1025, 1024), 1'b1, 16'h0400, 16'h0400});
        rows.push_back('{mk_pixel(16'hbeef), 1'b0, '0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_req(rows[i].item, rows[i].typed, rows[i].x_end, rows[i].y_end);
        settle();

        program_codes(8'h00, 8'hff, 8'h80);
        run_random(32);
        settle();

        program_codes(8'hff, 8'h00, 8'h7f);
        run_random(32);
        settle();

        program_codes(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
        run_random(32);
        settle();

        if (byte_mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/lwws_pkg.sv
rtl/lwws_if.sv
rtl/lwws_front.sv
rtl/lwws_job_fifo.sv
rtl/lwws_back.sv
rtl/lcd_window_write_sequencer.sv
dv/tb_lcd_window_write_sequencer.sv
